// ===== rtl/histogram_equalizer_assert.svh =====
// Assertion macros used by the file that checks its own logic.
`ifndef HISTOGRAM_EQUALIZER_ASSERT_SVH
`define HISTOGRAM_EQUALIZER_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define HEQ_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("histogram_equalizer: same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define HEQ_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("histogram_equalizer: next-cycle check failed");

`endif

// ===== rtl/heq_pkg.sv =====
package heq_pkg;

   localparam int MAX_PIXELS = 1048576;
   localparam int NUM_BINS   = 256;
   localparam int PIX_W      = 8;
   localparam int CNT_W      = $clog2(MAX_PIXELS + 1);
   localparam int CUM_W      = CNT_W + PIX_W;
   // 510 * cum needs nine more bits, and adding the total one more.
   localparam int NUM_W      = CUM_W + 10;
   localparam int DEN_W      = CNT_W + 1;
   localparam int DSH_W      = DEN_W + PIX_W;
   localparam int STEP_W     = $clog2(PIX_W + 1);

   localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_PIXELS);

   localparam logic [1:0] REQ_COUNT = 2'd0;
   localparam logic [1:0] REQ_BUILD = 2'd1;
   localparam logic [1:0] REQ_MAP   = 2'd2;

   typedef enum logic [3:0] {
      S_IDLE,
      S_CNT_WR,
      S_MAP_OUT,
      S_B_RD,
      S_B_ACC,
      S_B_NUM,
      S_B_DIV,
      S_B_WR
   } state_type;

   typedef struct packed {
      logic load;
      logic cnt_wr;
      logic build_start;
      logic bin_rd;
      logic bin_acc;
      logic num_calc;
      logic div_step;
      logic map_wr;
      logic build_clear;
   } dp_cmd_type;

   typedef struct packed {
      logic idx_last;
      logic step_last;
   } dp_status_type;

endpackage

// ===== rtl/heq_ctrl.sv =====
module heq_ctrl import heq_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  logic [1:0]    req_type,
   input  dp_status_type status,
   output logic          busy,
   output logic          rsp_strobe,
   output dp_cmd_type    cmd
);

   state_type state_ff, state_in;
   logic      accept;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign accept = start && (state_ff == S_IDLE);

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      busy       = 1'b1;
      rsp_strobe = 1'b0;
      case (state_ff)
         S_IDLE: begin
            busy     = 1'b0;
            cmd.load = accept;
            if (accept) begin
               case (req_type)
                  REQ_COUNT: state_in = S_CNT_WR;
                  REQ_BUILD: begin
                     cmd.build_start = 1'b1;
                     state_in        = S_B_RD;
                  end
                  REQ_MAP:   state_in = S_MAP_OUT;
                  default:   state_in = S_IDLE;
               endcase
            end
         end
         S_CNT_WR: begin
            cmd.cnt_wr = 1'b1;
            state_in   = S_IDLE;
         end
         S_MAP_OUT: begin
            rsp_strobe = 1'b1;
            state_in   = S_IDLE;
         end
         S_B_RD: begin
            cmd.bin_rd = 1'b1;
            state_in   = S_B_ACC;
         end
         S_B_ACC: begin
            cmd.bin_acc = 1'b1;
            state_in    = S_B_NUM;
         end
         S_B_NUM: begin
            cmd.num_calc = 1'b1;
            state_in     = S_B_DIV;
         end
         S_B_DIV: begin
            cmd.div_step = 1'b1;
            if (status.step_last) begin
               state_in = S_B_WR;
            end
         end
         S_B_WR: begin
            cmd.map_wr = 1'b1;
            if (status.idx_last) begin
               cmd.build_clear = 1'b1;
               state_in        = S_IDLE;
            end else begin
               state_in = S_B_RD;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

endmodule

// ===== rtl/heq_dpath.sv =====
module heq_dpath import heq_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  dp_cmd_type       cmd,
   input  logic [PIX_W-1:0] req_pixel_value,
   output dp_status_type    status,
   output logic [PIX_W-1:0] rsp_mapped_pixel
);

   logic [CNT_W-1:0]    bin_mem [NUM_BINS];
   logic [PIX_W-1:0]    map_mem [NUM_BINS];

   logic [NUM_BINS-1:0] bin_vld_ff, bin_vld_in;
   logic [NUM_BINS-1:0] map_vld_ff, map_vld_in;
   logic [CNT_W-1:0]    bin_q_ff;
   logic                bin_vld_q_ff;
   logic [PIX_W-1:0]    map_q_ff;
   logic                map_vld_q_ff;

   logic [PIX_W-1:0]    pix_ff, pix_in;
   logic [PIX_W-1:0]    idx_ff, idx_in;
   logic [CNT_W-1:0]    total_ff, total_in;
   logic [CUM_W-1:0]    cum_ff, cum_in;
   logic [NUM_W-1:0]    num_ff, num_in;
   logic [DSH_W-1:0]    dsh_ff, dsh_in;
   logic [PIX_W-1:0]    quo_ff, quo_in;
   logic                sat_ff, sat_in;
   logic [STEP_W-1:0]   step_ff, step_in;

   logic [PIX_W-1:0]    bin_rd_addr;
   logic [CNT_W-1:0]    bin_val;
   logic [CNT_W-1:0]    bin_inc;
   logic [PIX_W-1:0]    map_val;
   logic                rem_ge;

   assign bin_rd_addr = cmd.bin_rd ? idx_ff : req_pixel_value;
   assign bin_val     = bin_vld_q_ff ? bin_q_ff : '0;
   assign bin_inc     = (bin_val < MAX_CNT) ? bin_val + CNT_W'(1) : bin_val;
   assign rem_ge      = num_ff >= NUM_W'(dsh_ff);
   assign map_val     = (total_ff == '0) ? '0 : (sat_ff ? '1 : quo_ff);

   assign rsp_mapped_pixel = map_vld_q_ff ? map_q_ff : '0;
   assign status.idx_last  = idx_ff == '1;
   assign status.step_last = step_ff == STEP_W'(PIX_W);

   always_ff @(posedge clock) begin
      bin_q_ff     <= bin_mem[bin_rd_addr];
      bin_vld_q_ff <= bin_vld_ff[bin_rd_addr];
      if (cmd.cnt_wr) begin
         bin_mem[pix_ff] <= bin_inc;
      end
   end

   always_ff @(posedge clock) begin
      map_q_ff     <= map_mem[req_pixel_value];
      map_vld_q_ff <= map_vld_ff[req_pixel_value];
      if (cmd.map_wr) begin
         map_mem[idx_ff] <= map_val;
      end
   end

   always_comb begin
      bin_vld_in = bin_vld_ff;
      map_vld_in = map_vld_ff;
      pix_in     = pix_ff;
      idx_in     = idx_ff;
      total_in   = total_ff;
      cum_in     = cum_ff;
      num_in     = num_ff;
      dsh_in     = dsh_ff;
      quo_in     = quo_ff;
      sat_in     = sat_ff;
      step_in    = step_ff;

      if (cmd.load) begin
         pix_in = req_pixel_value;
      end
      if (cmd.cnt_wr) begin
         bin_vld_in[pix_ff] = 1'b1;
         if (total_ff < MAX_CNT) begin
            total_in = total_ff + CNT_W'(1);
         end
      end
      if (cmd.build_start) begin
         idx_in = '0;
         cum_in = '0;
      end
      if (cmd.bin_acc) begin
         cum_in = cum_ff + CUM_W'(bin_val);
      end
      if (cmd.num_calc) begin
         // 510 * cum + total, with the divisor 2 * total aligned to the
         // first quotient weight past the eight result bits.
         num_in  = NUM_W'({cum_ff, 9'd0}) - NUM_W'({cum_ff, 1'b0}) + NUM_W'(total_ff);
         dsh_in  = DSH_W'({total_ff, 1'b0, {PIX_W{1'b0}}});
         quo_in  = '0;
         sat_in  = 1'b0;
         step_in = '0;
      end
      if (cmd.div_step) begin
         // The first step only detects a quotient of 256 or more.
         if (step_ff == '0) begin
            sat_in = rem_ge;
         end else if (rem_ge) begin
            num_in = num_ff - NUM_W'(dsh_ff);
            quo_in = {quo_ff[PIX_W-2:0], 1'b1};
         end else begin
            quo_in = {quo_ff[PIX_W-2:0], 1'b0};
         end
         dsh_in  = dsh_ff >> 1;
         step_in = step_ff + STEP_W'(1);
      end
      if (cmd.map_wr) begin
         map_vld_in[idx_ff] = 1'b1;
         idx_in             = idx_ff + PIX_W'(1);
      end
      if (cmd.build_clear) begin
         bin_vld_in = '0;
         total_in   = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bin_vld_ff <= '0;
         map_vld_ff <= '0;
         total_ff   <= '0;
         idx_ff     <= '0;
         step_ff    <= '0;
      end else begin
         bin_vld_ff <= bin_vld_in;
         map_vld_ff <= map_vld_in;
         total_ff   <= total_in;
         idx_ff     <= idx_in;
         step_ff    <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      pix_ff <= pix_in;
      cum_ff <= cum_in;
      num_ff <= num_in;
      dsh_ff <= dsh_in;
      quo_ff <= quo_in;
      sat_ff <= sat_in;
   end

endmodule

// ===== rtl/histogram_equalizer.sv =====
// Channel   Ports                                   Transfer
// request   req_type, req_pixel_value               start && !busy at clock edge
// response  rsp_mapped_pixel                        rsp_strobe, one cycle, no stall
//
// Count and map requests read the bin or map memory, whose read data is
// registered, and then write back or present the result.
// A build request runs per bin one read, one add, one numerator step, nine
// steps of the shared one-bit-per-cycle divider and one map memory write.
// Synchronous reset clears the valid bits of both memories and the total.
// The response appears the cycle after the map request's transfer.
`include "histogram_equalizer_assert.svh"

module histogram_equalizer import heq_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  logic [1:0]       req_type,
   input  logic [PIX_W-1:0] req_pixel_value,
   output logic             rsp_strobe,
   output logic [PIX_W-1:0] rsp_mapped_pixel
);

   dp_cmd_type    cmd;
   dp_status_type status;

   heq_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .req_type   (req_type),
      .status     (status),
      .busy       (busy),
      .rsp_strobe (rsp_strobe),
      .cmd        (cmd)
   );

   heq_dpath u_dpath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .req_pixel_value  (req_pixel_value),
      .status           (status),
      .rsp_mapped_pixel (rsp_mapped_pixel)
   );

   `HEQ_ASSERT_NEXT(a_map_gives_rsp, clock, reset, start && !busy && req_type == REQ_MAP, rsp_strobe)
   `HEQ_ASSERT_NEXT(a_rsp_then_idle, clock, reset, rsp_strobe, !busy && !rsp_strobe)
   `HEQ_ASSERT_NEXT(a_build_busy, clock, reset, start && !busy && req_type == REQ_BUILD, busy && !rsp_strobe)
   `HEQ_ASSERT_SAME(a_rsp_only_busy, clock, reset, rsp_strobe, busy)

endmodule

// ===== tb/histogram_equalizer_tb.sv =====
module histogram_equalizer_tb;
   import heq_pkg::*;

   localparam logic [1:0] REQ_UNUSED   = 2'd3;
   localparam int         BUILD_CYCLES = 1 + NUM_BINS * 13;
   localparam int         DRAIN_CYCLES = BUILD_CYCLES + 64;
   localparam int         RANDOM_ITEMS = 1950;
   localparam int         MAX_REPORTS  = 10;

   typedef struct {
      logic [1:0]       kind;
      logic [PIX_W-1:0] pixel;
   } pixel_req_type;

   logic             clock;
   logic             reset = 1'b1;
   logic             start = 1'b0;
   logic             busy;
   logic [1:0]       req_type = REQ_COUNT;
   logic [PIX_W-1:0] req_pixel_value = '0;
   logic             rsp_strobe;
   logic [PIX_W-1:0] rsp_mapped_pixel;

   // Expected state of the equalizer, kept alongside the block.
   logic [CNT_W-1:0] hist_bins[NUM_BINS];
   logic [CNT_W-1:0] hist_total;
   logic [PIX_W-1:0] level_lut[NUM_BINS];

   pixel_req_type    pending_reqs[$];
   logic [PIX_W-1:0] expected_levels[$];

   int     error_count = 0;
   int     n_builds = 0;
   int     idle_left = 0;
   bit     no_idle = 1'b0;
   longint cycle_count = 0;
   longint cycle_limit = 64'd1000000;

   histogram_equalizer dut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_type         (req_type),
      .req_pixel_value  (req_pixel_value),
      .rsp_strobe       (rsp_strobe),
      .rsp_mapped_pixel (rsp_mapped_pixel)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   task automatic note_failure(input string what, input int exp_val, input int act_val);
      error_count++;
      if (error_count <= MAX_REPORTS)
         $display("mismatch: %s expected %0d actual %0d", what, exp_val, act_val);
   endtask

   task automatic queue_req(input logic [1:0] kind, input logic [PIX_W-1:0] pixel);
      pixel_req_type r;
      r.kind  = kind;
      r.pixel = pixel;
      pending_reqs.insert(pending_reqs.size(), r);
      if (kind == REQ_BUILD)
         n_builds++;
   endtask

   task automatic build_level_lut();
      logic [63:0] running;
      logic [63:0] scaled;
      running = '0;
      for (int b = 0; b < NUM_BINS; b++) begin
         running += 64'(hist_bins[b]);
         if (hist_total == '0) begin
            level_lut[b] = '0;
         end else begin
            // Round to nearest with halves going up, in integers.
            scaled = (64'd510 * running + 64'(hist_total)) / (64'd2 * 64'(hist_total));
            level_lut[b] = (scaled > 64'd255) ? 8'hFF : scaled[PIX_W-1:0];
         end
      end
      foreach (hist_bins[b])
         hist_bins[b] = '0;
      hist_total = '0;
   endtask

   task automatic equalize_request(input logic [1:0] kind, input logic [PIX_W-1:0] pixel);
      case (kind)
         REQ_COUNT: begin
            if (hist_bins[pixel] < MAX_CNT)
               hist_bins[pixel]++;
            if (hist_total < MAX_CNT)
               hist_total++;
         end
         REQ_BUILD: begin
            build_level_lut();
         end
         REQ_MAP: begin
            expected_levels.insert(expected_levels.size(), level_lut[pixel]);
         end
         default: begin
         end
      endcase
   endtask

   // Request driver: one transfer per start && !busy edge, random gaps between items.
   always @(posedge clock) begin
      logic          accepted;
      pixel_req_type nxt;
      accepted = start && !busy;
      if (reset) begin
         start <= 1'b0;
      end else begin
         if (accepted) begin
            equalize_request(req_type, req_pixel_value);
            if ($urandom_range(0, 59) == 0)
               no_idle = !no_idle;
            idle_left = no_idle ? 0 : $urandom_range(0, 9);
         end
         if (start && !accepted) begin
            start <= 1'b1;
         end else if (idle_left != 0) begin
            idle_left--;
            start <= 1'b0;
         end else if (pending_reqs.size() != 0) begin
            nxt = pending_reqs.pop_front();
            start <= 1'b1;
            req_type <= nxt.kind;
            req_pixel_value <= nxt.pixel;
         end else begin
            start <= 1'b0;
         end
      end
   end

   // Response monitor: every strobe must match the oldest outstanding map request.
   always @(posedge clock) begin
      logic [PIX_W-1:0] want;
      if (!reset && rsp_strobe) begin
         if (expected_levels.size() == 0) begin
            note_failure("response with no map request outstanding", -1,
                         int'(rsp_mapped_pixel));
         end else begin
            want = expected_levels.pop_front();
            if (rsp_mapped_pixel !== want)
               note_failure("mapped_pixel", int'(want), int'(rsp_mapped_pixel));
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > cycle_limit) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   initial begin
      int lo;
      int hi;
      int n_cnt;
      int n_map;

      foreach (hist_bins[b])
         hist_bins[b] = '0;
      hist_total = '0;
      foreach (level_lut[b])
         level_lut[b] = '0;

      // Map reads before any build, then a build over an empty histogram.
      queue_req(REQ_MAP, 8'd0);
      queue_req(REQ_MAP, 8'd255);
      queue_req(REQ_BUILD, 8'd0);
      queue_req(REQ_MAP, 8'd128);
      // The unused request code must leave everything untouched.
      queue_req(REQ_UNUSED, 8'hFF);
      queue_req(REQ_UNUSED, 8'h00);
      queue_req(REQ_COUNT, 8'd0);
      queue_req(REQ_COUNT, 8'd255);
      queue_req(REQ_COUNT, 8'd255);
      queue_req(REQ_COUNT, 8'hAA);
      queue_req(REQ_COUNT, 8'h55);
      queue_req(REQ_UNUSED, 8'h55);
      queue_req(REQ_BUILD, 8'hFF);
      queue_req(REQ_MAP, 8'd0);
      queue_req(REQ_MAP, 8'd255);
      queue_req(REQ_MAP, 8'hAA);
      queue_req(REQ_MAP, 8'h55);
      queue_req(REQ_MAP, 8'd1);
      queue_req(REQ_MAP, 8'd254);
      queue_req(REQ_BUILD, 8'd7);
      queue_req(REQ_MAP, 8'd255);

      // Random part: histogram fill, build, then lookups, with a little noise mixed in.
      while (pending_reqs.size() < RANDOM_ITEMS - 60) begin
         lo = $urandom_range(0, 255);
         hi = $urandom_range(lo, 255);
         if ($urandom_range(0, 3) == 0) begin
            lo = 0;
            hi = 255;
         end
         n_cnt = ($urandom_range(0, 14) == 0) ? 0 : $urandom_range(1, 80);
         repeat (n_cnt) begin
            case ($urandom_range(0, 19))
               0:       queue_req(REQ_UNUSED, PIX_W'($urandom_range(0, 255)));
               1:       queue_req(REQ_MAP, PIX_W'($urandom_range(0, 255)));
               default: queue_req(REQ_COUNT, PIX_W'($urandom_range(lo, hi)));
            endcase
         end
         queue_req(REQ_BUILD, PIX_W'($urandom_range(0, 255)));
         if ($urandom_range(0, 9) == 0)
            queue_req(REQ_BUILD, PIX_W'($urandom_range(0, 255)));
         n_map = $urandom_range(1, 40);
         repeat (n_map) begin
            case ($urandom_range(0, 19))
               0:       queue_req(REQ_UNUSED, PIX_W'($urandom_range(0, 255)));
               1:       queue_req(REQ_COUNT, PIX_W'($urandom_range(0, 255)));
               2:       queue_req(REQ_MAP, PIX_W'($urandom_range(lo, hi)));
               default: queue_req(REQ_MAP, PIX_W'($urandom_range(0, 255)));
            endcase
         end
      end

      cycle_limit = 4 * (longint'(pending_reqs.size()) * 14
                         + longint'(n_builds) * (BUILD_CYCLES + 12)) + 20000;

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      while (pending_reqs.size() != 0 || start || expected_levels.size() != 0)
         @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);

      if (expected_levels.size() != 0)
         note_failure("map responses never seen", 0, expected_levels.size());

      if (error_count == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule
